>>> rtl/ssp_pkg.sv
// ----------------------------------------------------------------------------
// ssp_pkg
// Shared types and constants of the stride/sequential prefetcher.
// ----------------------------------------------------------------------------
`default_nettype none
package ssp_pkg;
    localparam int TABLE_ENTRIES_DEF = 16;
    localparam int QUEUE_DEPTH_DEF   = 32;
    localparam int CFG_IDX_W         = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NEW_STRIDE  = 3'd0,
        CFG_NEW_DEGREE  = 3'd1,
        CFG_MISS_STRIDE = 3'd2,
        CFG_MISS_DEGREE = 3'd3,
        CFG_MAX_DEGREE  = 3'd4,
        CFG_L1_SHIFT    = 3'd5,
        CFG_L2_SHIFT    = 3'd6,
        CFG_UNUSED      = 3'd7
    } cfg_idx_t;

    typedef enum logic [1:0] {
        MODE_INIT   = 2'd0,
        MODE_TRANS  = 2'd1,
        MODE_STEADY = 2'd2,
        MODE_NOPRE  = 2'd3
    } mode_t;

    // Work handed from the table front end to the queue back end
    typedef struct packed {
        logic        pop;       // pop the queue head
        logic        seq;       // sequential run, else stride run
        logic        none;      // no prefetches
        logic [31:0] addr;
        logic [15:0] stride;
        logic [16:0] first;     // first multiplier (seq: -1 encoded as start)
        logic [16:0] last;      // last multiplier, inclusive
        logic        use_l1;
    } job_t;
endpackage
`default_nettype wire

>>> rtl/stride_sequential_prefetcher.sv
// ----------------------------------------------------------------------------
// stride_sequential_prefetcher
// Per-PC stride/sequential prefetcher with a deduplicating prefetch queue.
// ----------------------------------------------------------------------------
// An item (CPU access or pop) is taken when start is high and busy low; one
// status result follows on the strobe, which the receiver must take and
// cannot stall. A CPU access passes the table's scan, update and output
// states and the job queue, then each prefetch candidate takes a multiply and
// a candidate step plus a read and a compare per queued address scanned for
// duplicates (one scan pass even when the queue is empty; a sequential
// candidate inside the access's own block skips the scan), since the queue
// store has one read port; a head read comes before the strobe. busy stays
// high until the strobe, so one item is in flight at a time.
`default_nettype none
module stride_sequential_prefetcher #(
    parameter int TABLE_ENTRIES = ssp_pkg::TABLE_ENTRIES_DEF,
    parameter int QUEUE_DEPTH   = ssp_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        req_type,
    input  wire logic [31:0] access_pc,
    input  wire logic [31:0] access_addr,
    input  wire logic        hit_l1,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [ssp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [15:0] cfg_data,
    output logic             strobe,
    output logic             pending_valid,
    output logic [31:0]      pending_addr,
    output logic [4:0]       pending_count
);
    import ssp_pkg::*;

    logic [15:0] new_stride_reg, miss_stride_reg;
    logic [7:0]  new_degree_reg, miss_degree_reg, max_degree_reg;
    logic [3:0]  l1_shift_reg, l2_shift_reg;

    assign cfg_ready = 1'b1;

    // Write configuration registers on each transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            new_stride_reg  <= 16'd64;
            new_degree_reg  <= 8'd2;
            miss_stride_reg <= 16'd64;
            miss_degree_reg <= 8'd1;
            max_degree_reg  <= 8'd4;
            l1_shift_reg    <= 4'd5;
            l2_shift_reg    <= 4'd6;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_NEW_STRIDE:  new_stride_reg  <= cfg_data;
                CFG_NEW_DEGREE:  new_degree_reg  <= cfg_data[7:0];
                CFG_MISS_STRIDE: miss_stride_reg <= cfg_data;
                CFG_MISS_DEGREE: miss_degree_reg <= cfg_data[7:0];
                CFG_MAX_DEGREE:  max_degree_reg  <= cfg_data[7:0];
                CFG_L1_SHIFT:    l1_shift_reg    <= cfg_data[3:0];
                CFG_L2_SHIFT:    l2_shift_reg    <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // Track items in flight so busy covers the whole job
    logic in_ready, done, busy_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else if (start && !busy)
            busy_reg <= 1'b1;
        else if (done)
            busy_reg <= 1'b0;
    end
    assign busy = busy_reg || !in_ready;

    job_t f_job, b_job;
    logic f_valid, f_ready, b_valid, b_ready;

    ssp_table #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_table (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (start && !busy),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .access_pc   (access_pc),
        .access_addr (access_addr),
        .hit_l1      (hit_l1),
        .new_stride  (new_stride_reg),
        .new_degree  (new_degree_reg),
        .miss_stride (miss_stride_reg),
        .miss_degree (miss_degree_reg),
        .max_degree  (max_degree_reg),
        .job         (f_job),
        .job_valid   (f_valid),
        .job_ready   (f_ready)
    );

    ssp_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_job   (f_job),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .rd_job   (b_job),
        .rd_valid (b_valid),
        .rd_ready (b_ready)
    );

    ssp_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue (
        .clk            (clk),
        .rst_n          (rst_n),
        .job            (b_job),
        .job_valid      (b_valid),
        .job_ready      (b_ready),
        .l1_block_shift (l1_shift_reg),
        .l2_block_shift (l2_shift_reg),
        .done           (done),
        .pending_valid  (pending_valid),
        .pending_addr   (pending_addr),
        .pending_count  (pending_count)
    );

    assign strobe = done;
endmodule
`default_nettype wire

>>> rtl/ssp_table.sv
// ----------------------------------------------------------------------------
// ssp_table
// Front end: per-PC reference table lookup, LRU replacement and mode update.
// Emits one prefetch job per accepted item.
// ----------------------------------------------------------------------------
`default_nettype none
module ssp_table #(
    parameter int TABLE_ENTRIES = ssp_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire logic         req_type,
    input  wire logic [31:0]  access_pc,
    input  wire logic [31:0]  access_addr,
    input  wire logic         hit_l1,
    input  wire logic [15:0]  new_stride,
    input  wire logic [7:0]   new_degree,
    input  wire logic [15:0]  miss_stride,
    input  wire logic [7:0]   miss_degree,
    input  wire logic [7:0]   max_degree,
    output ssp_pkg::job_t     job,
    output logic              job_valid,
    input  wire logic         job_ready
);
    import ssp_pkg::*;
    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int UW = $clog2(TABLE_ENTRIES + 1);

    typedef enum logic [1:0] { S_IDLE, S_SCAN, S_UPD, S_OUT } state_t;

    logic [31:0]    pc_q   [TABLE_ENTRIES];
    logic [31:0]    last_q [TABLE_ENTRIES];
    logic [15:0]    cnt_q  [TABLE_ENTRIES];
    logic [15:0]    str_q  [TABLE_ENTRIES];
    logic [15:0]    ahd_q  [TABLE_ENTRIES];
    mode_t          mode_q [TABLE_ENTRIES];
    logic [IW-1:0]  rank_q [TABLE_ENTRIES];

    state_t         state_reg;
    logic [UW-1:0]  used_reg;
    logic [IW-1:0]  idx_reg;
    logic           found_reg;
    logic           req_reg, l1_reg;
    logic [31:0]    pc_reg, addr_reg;
    job_t           job_reg;

    // Parallel compare against valid entries, as combinational hit and LRU vectors
    logic [TABLE_ENTRIES-1:0] hit_vec, lru_vec;
    always_comb
    begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            hit_vec[i] = (UW'(i) < used_reg) && (pc_q[i] == pc_reg);
            lru_vec[i] = (UW'(i) < used_reg) &&
                         (UW'(rank_q[i]) == used_reg - UW'(1));
        end
    end

    logic [IW-1:0] hit_idx, lru_idx;
    always_comb
    begin
        hit_idx = '0;
        lru_idx = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            if (hit_vec[i]) hit_idx = IW'(i);
            if (lru_vec[i]) lru_idx = IW'(i);
        end
    end

    // Entry update arithmetic for the selected entry
    logic [15:0] e_cnt, e_str, e_ahd, delta, ahd_dec, lim, cnt_new;
    mode_t       e_mode;
    always_comb
    begin
        e_cnt  = cnt_q[idx_reg];
        e_str  = str_q[idx_reg];
        e_ahd  = ahd_q[idx_reg];
        e_mode = mode_q[idx_reg];
        delta  = addr_reg[15:0] - last_q[idx_reg][15:0];
        ahd_dec = (e_ahd != 16'd0) ? e_ahd - 16'd1 : 16'd0;
        unique case (e_mode)
            MODE_INIT:   cnt_new = (e_cnt != 16'hFFFF) ? e_cnt + 16'd1 : e_cnt;
            MODE_STEADY: cnt_new = (e_cnt > 16'hFFFB) ? 16'hFFFF : e_cnt + 16'd4;
            default:     cnt_new = 16'd2;
        endcase
        lim = (cnt_new < {8'd0, max_degree}) ? cnt_new : {8'd0, max_degree};
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign job       = job_reg;
    assign job_valid = (state_reg == S_OUT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            used_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        req_reg   <= req_type;
                        pc_reg    <= access_pc;
                        addr_reg  <= access_addr;
                        l1_reg    <= hit_l1;
                        state_reg <= req_type ? S_UPD : S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    found_reg <= |hit_vec;
                    if (|hit_vec)
                        idx_reg <= hit_idx;
                    else if (used_reg < UW'(TABLE_ENTRIES))
                        idx_reg <= used_reg[IW-1:0];
                    else
                        idx_reg <= lru_idx;
                    state_reg <= S_UPD;
                end
                S_UPD:
                begin
                    job_reg.pop    <= req_reg;
                    job_reg.addr   <= addr_reg;
                    job_reg.use_l1 <= l1_reg;
                    job_reg.none   <= 1'b0;
                    if (!req_reg)
                    begin
                        // promote to most recent; a fresh entry ages every valid one
                        for (int j = 0; j < TABLE_ENTRIES; j++)
                            if ((UW'(j) < used_reg) &&
                                ((!found_reg && used_reg < UW'(TABLE_ENTRIES)) ||
                                 rank_q[j] < rank_q[idx_reg]))
                                rank_q[j] <= rank_q[j] + IW'(1);
                        rank_q[idx_reg] <= '0;
                        last_q[idx_reg] <= addr_reg;
                        if (!found_reg)
                        begin
                            if (used_reg < UW'(TABLE_ENTRIES))
                                used_reg <= used_reg + UW'(1);
                            pc_q[idx_reg]   <= pc_reg;
                            cnt_q[idx_reg]  <= 16'd1;
                            str_q[idx_reg]  <= new_stride;
                            ahd_q[idx_reg]  <= {8'd0, new_degree};
                            mode_q[idx_reg] <= MODE_INIT;
                            job_reg.seq     <= 1'b1;
                            job_reg.stride  <= new_stride;
                            job_reg.first   <= '0;
                            job_reg.last    <= 17'(new_degree) + 17'd1;
                        end
                        else if (delta == e_str)
                        begin
                            job_reg.stride <= e_str;
                            if (e_mode == MODE_NOPRE)
                            begin
                                mode_q[idx_reg] <= MODE_TRANS;
                                cnt_q[idx_reg]  <= 16'd2;
                                ahd_q[idx_reg]  <= ahd_dec;
                                job_reg.seq     <= 1'b1;
                                job_reg.first   <= '0;
                                job_reg.last    <= {1'b0, ahd_dec} + 17'd1;
                            end
                            else
                            begin
                                mode_q[idx_reg] <= MODE_STEADY;
                                cnt_q[idx_reg]  <= cnt_new;
                                job_reg.seq     <= 1'b0;
                                job_reg.first   <= {1'b0, ahd_dec} + 17'd1;
                                job_reg.last    <= {1'b0, lim};
                                job_reg.none    <= (e_str == 16'd0) || !(ahd_dec < lim);
                                if (e_str != 16'd0 && ahd_dec < lim)
                                    ahd_q[idx_reg] <= lim;
                                else
                                    ahd_q[idx_reg] <= ahd_dec;
                            end
                        end
                        else
                        begin
                            mode_q[idx_reg] <= (e_mode == MODE_TRANS || e_mode == MODE_NOPRE)
                                               ? MODE_NOPRE : MODE_TRANS;
                            cnt_q[idx_reg]  <= 16'd1;
                            str_q[idx_reg]  <= delta;
                            ahd_q[idx_reg]  <= {8'd0, new_degree};
                            job_reg.seq     <= 1'b1;
                            job_reg.stride  <= miss_stride;
                            job_reg.first   <= '0;
                            job_reg.last    <= 17'(miss_degree) + 17'd1;
                        end
                    end
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (job_ready)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> rtl/ssp_fifo.sv
// ----------------------------------------------------------------------------
// ssp_fifo
// Two-entry job queue between the table front end and the queue back end.
// ----------------------------------------------------------------------------
`default_nettype none
module ssp_fifo (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  ssp_pkg::job_t wr_job,
    input  wire logic     wr_valid,
    output logic          wr_ready,
    output ssp_pkg::job_t rd_job,
    output logic          rd_valid,
    input  wire logic     rd_ready
);
    import ssp_pkg::*;
    job_t       mem_q [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_job   = mem_q[rp_reg];

    // Hold entries and advance pointers on each transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr_valid && wr_ready)
            begin
                mem_q[wp_reg] <= wr_job;
                wp_reg <= ~wp_reg;
            end
            if (rd_valid && rd_ready)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'((wr_valid && wr_ready) ? 1 : 0)
                               - 2'((rd_valid && rd_ready) ? 1 : 0);
        end
    end
endmodule
`default_nettype wire

>>> rtl/ssp_ram.sv
// ----------------------------------------------------------------------------
// ssp_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module ssp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

>>> rtl/ssp_queue.sv
// ----------------------------------------------------------------------------
// ssp_queue
// Back end: generates prefetch candidates, scans the circular queue for
// block duplicates, enqueues, pops, and strobes the queue status.
// ----------------------------------------------------------------------------
`default_nettype none
module ssp_queue #(
    parameter int QUEUE_DEPTH = ssp_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  ssp_pkg::job_t    job,
    input  wire logic        job_valid,
    output logic             job_ready,
    input  wire logic [3:0]  l1_block_shift,
    input  wire logic [3:0]  l2_block_shift,
    output logic             done,
    output logic             pending_valid,
    output logic [31:0]      pending_addr,
    output logic [4:0]       pending_count
);
    import ssp_pkg::*;
    localparam int QW = $clog2(QUEUE_DEPTH);

    typedef enum logic [2:0] { B_IDLE, B_CAND, B_MUL, B_SCAN, B_RD, B_HEAD, B_OUT, B_POP }
        state_t;

    state_t        state_reg;
    job_t          job_reg;
    logic [QW-1:0] front_reg, rear_reg, k_reg;
    logic [16:0]   i_reg;
    logic [31:0]   prod_reg, cand_reg;
    logic          done_reg;
    logic [31:0]   head_reg;

    logic [QW-1:0] len;
    assign len = rear_reg - front_reg;

    logic          ram_we;
    logic [QW-1:0] ram_raddr;
    logic [31:0]   ram_rdata;

    ssp_ram #(.WIDTH(32), .DEPTH(QUEUE_DEPTH)) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (rear_reg),
        .wdata (cand_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    logic [3:0]  dsh, ash;
    logic [31:0] cand_sum;
    assign dsh = (job_reg.seq || !job_reg.use_l1) ? l2_block_shift : l1_block_shift;
    assign ash = job_reg.use_l1 ? l1_block_shift : l2_block_shift;
    assign cand_sum = job_reg.addr + prod_reg;

    // Multiplier: seq runs from -1, stride runs from the first lookahead step
    logic [16:0] mul_k;
    logic [31:0] mul_ext;
    assign mul_k   = job_reg.seq ? i_reg - 17'd1 : i_reg;
    assign mul_ext = job_reg.seq ? {{15{mul_k[16]}}, mul_k} : {15'd0, mul_k};

    logic k_last;
    assign k_last = (k_reg == len - QW'(1));
    assign ram_raddr = (state_reg == B_HEAD || state_reg == B_IDLE || state_reg == B_POP)
                     ? front_reg : front_reg + k_reg;
    assign ram_we = (state_reg == B_OUT) && (len == QW'(0) || k_last) &&
                    !((len != QW'(0)) && ((ram_rdata >> dsh) == (cand_reg >> dsh))) &&
                    (len != QW'(QUEUE_DEPTH - 1));

    assign job_ready     = (state_reg == B_IDLE);
    assign done          = done_reg;
    assign pending_valid = done_reg && (len != QW'(0));
    assign pending_addr  = (len != QW'(0)) ? head_reg : 32'd0;
    assign pending_count = 5'(len);

    // Sequence one job: candidates one at a time, queue entries read and compared in turn
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            front_reg <= '0;
            rear_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                B_IDLE:
                begin
                    if (job_valid)
                    begin
                        job_reg <= job;
                        i_reg   <= job.first;
                        if (job.pop)
                        begin
                            if (len != QW'(0))
                                front_reg <= front_reg + QW'(1);
                            state_reg <= B_POP;
                        end
                        else if (job.none || job.stride == 16'd0)
                            state_reg <= B_RD;
                        else
                            state_reg <= B_MUL;
                    end
                end
                B_POP:
                begin
                    // read the new head after the front moved
                    state_reg <= B_RD;
                end
                B_MUL:
                begin
                    prod_reg  <= mul_ext * {{16{job_reg.stride[15]}}, job_reg.stride};
                    state_reg <= B_CAND;
                end
                B_CAND:
                begin
                    cand_reg <= cand_sum;
                    k_reg    <= '0;
                    if (job_reg.seq && ((cand_sum >> ash) == (job_reg.addr >> ash)))
                        state_reg <= B_HEAD;
                    else
                        state_reg <= B_SCAN;
                end
                B_SCAN:
                begin
                    // wait for the registered read of entry k
                    state_reg <= B_OUT;
                end
                B_OUT:
                begin
                    if (len == QW'(0) || (ram_rdata >> dsh) == (cand_reg >> dsh)
                        || k_last)
                        state_reg <= B_HEAD;
                    else
                    begin
                        k_reg     <= k_reg + QW'(1);
                        state_reg <= B_SCAN;
                    end
                end
                B_HEAD:
                begin
                    if (i_reg == job_reg.last)
                        state_reg <= B_RD;
                    else
                    begin
                        i_reg     <= i_reg + 17'd1;
                        state_reg <= B_MUL;
                    end
                end
                B_RD:
                begin
                    head_reg  <= ram_rdata;
                    done_reg  <= 1'b1;
                    state_reg <= B_IDLE;
                end
                default: state_reg <= B_IDLE;
            endcase
            if (ram_we)
                rear_reg <= rear_reg + QW'(1);
        end
    end
endmodule
`default_nettype wire
